FILE: rtl/hbt_pkg.sv
package hbt_pkg;

   localparam int MEMBERS_DEF = 16;
   localparam int MEMBER_W    = 4;
   localparam int WAIT_W      = 14;
   localparam int CD_W        = 16;

   localparam logic [WAIT_W-1:0] INIT_WAIT_RESET = 14'd6;
   localparam logic [WAIT_W-1:0] WAIT_MAX        = 14'h3FFF;
   localparam logic [CD_W-1:0]   CD_MIN          = 16'h8000;

   typedef enum logic [1:0] {
      OP_BEAT   = 2'd0,
      OP_TICK   = 2'd1,
      OP_ADD    = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_SWEEP = 1'b1
   } state_type;

   typedef struct packed {
      logic                active;
      op_type              op;
      logic [MEMBER_W-1:0] member;
   } tok_type;

   typedef struct packed {
      logic                suspect;
      logic                known;
      logic [MEMBER_W-1:0] slot;
   } stat_type;

endpackage

FILE: rtl/hbt_cell.sv
module hbt_cell #(
   parameter int INDEX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hbt_pkg::tok_type            tok_in,
   input  logic [hbt_pkg::WAIT_W-1:0]  initial_wait,
   output hbt_pkg::tok_type            tok_out,
   output hbt_pkg::stat_type           stat
);

   logic                              present_ff, present_in;
   logic                              heard_ff, heard_in;
   logic signed [hbt_pkg::CD_W-1:0]   cd_ff, cd_in;
   logic [hbt_pkg::WAIT_W-1:0]        max_ff, max_in;
   hbt_pkg::tok_type                  tok_ff;

   logic                              hit;
   logic                              ticking;
   logic signed [hbt_pkg::CD_W-1:0]   cd_dec;
   logic signed [18:0]                test_sum;
   logic                              over_bound;
   logic signed [17:0]                diff;
   logic signed [18:0]                dbl;
   logic signed [18:0]                max_ext;
   logic [hbt_pkg::WAIT_W-1:0]        grown;

   assign hit     = tok_in.active && (int'(tok_in.member) == INDEX);
   assign ticking = tok_in.active && (tok_in.op == hbt_pkg::OP_TICK) && present_ff && heard_ff;

   always_comb begin
      cd_dec     = (cd_ff == $signed(hbt_pkg::CD_MIN)) ? cd_ff : cd_ff - 16'sd1;
      test_sum   = $signed({{2{cd_dec[15]}}, cd_dec, 1'b0})
                 + $signed({5'b0, max_ff}) + $signed({4'b0, max_ff, 1'b0});
      over_bound = test_sum[18] || (test_sum == 19'sd0);
      diff       = $signed({4'b0, max_ff}) - $signed({{2{cd_ff[15]}}, cd_ff});
      dbl        = $signed({diff, 1'b0});
      max_ext    = $signed({5'b0, max_ff});
      if (dbl < max_ext) begin
         grown = max_ff;
      end else if (dbl > $signed({5'b0, hbt_pkg::WAIT_MAX})) begin
         grown = hbt_pkg::WAIT_MAX;
      end else begin
         grown = dbl[hbt_pkg::WAIT_W-1:0];
      end
   end

   always_comb begin
      present_in = present_ff;
      heard_in   = heard_ff;
      cd_in      = cd_ff;
      max_in     = max_ff;
      if (ticking) begin
         cd_in = cd_dec;
      end else if (hit) begin
         case (tok_in.op)
            hbt_pkg::OP_BEAT: begin
               if (present_ff) begin
                  if (!heard_ff) begin
                     heard_in = 1'b1;
                     cd_in    = $signed({2'b0, max_ff});
                  end else begin
                     max_in = grown;
                     cd_in  = $signed({2'b0, grown});
                  end
               end
            end
            hbt_pkg::OP_ADD: begin
               if (!present_ff) begin
                  present_in = 1'b1;
                  heard_in   = 1'b0;
                  cd_in      = '0;
                  max_in     = initial_wait;
               end
            end
            hbt_pkg::OP_REMOVE: begin
               present_in = 1'b0;
               heard_in   = 1'b0;
               cd_in      = '0;
               max_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      stat.suspect = ticking && over_bound;
      stat.known   = hit && (tok_in.op == hbt_pkg::OP_BEAT) && present_ff;
      stat.slot    = stat.suspect ? hbt_pkg::MEMBER_W'(INDEX) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         heard_ff   <= 1'b0;
         cd_ff      <= '0;
         max_ff     <= '0;
         tok_ff     <= '0;
      end else begin
         present_ff <= present_in;
         heard_ff   <= heard_in;
         cd_ff      <= cd_in;
         max_ff     <= max_in;
         tok_ff     <= tok_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

FILE: rtl/heartbeat_adaptive_timeout_table_core.sv
// Channel    Ports                      Transfer
// request    start, busy, req_*         rising edge with start high and busy low
// response   rsp_strobe, rsp_*          each cycle with rsp_strobe high
// config     csr_we, csr_wdata          rising edge with csr_we high
//
// Every operation sends a token down the row of MEMBERS cells, one cell per cycle, and busy
// stays high until the token leaves the last cell; a new request is taken only while idle.
// Each suspect is held until the next one or the end of the row so that the final result can
// carry rsp_last. Reset is synchronous, clears every slot and sets initial_wait to six; the
// receiver cannot stall.
module heartbeat_adaptive_timeout_table_core #(
   parameter int MEMBERS = hbt_pkg::MEMBERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_opcode,
   input  logic [hbt_pkg::MEMBER_W-1:0]  req_member,
   output logic                          rsp_strobe,
   output logic                          rsp_suspect,
   output logic [hbt_pkg::MEMBER_W-1:0]  rsp_member_out,
   output logic                          rsp_unknown,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [hbt_pkg::WAIT_W-1:0]    csr_wdata
);

   hbt_pkg::state_type                state_ff, state_in;
   hbt_pkg::tok_type                  tok_ff, tok_in;
   hbt_pkg::tok_type                  tok_chain [MEMBERS+1];
   hbt_pkg::stat_type                 stats [MEMBERS];
   logic [MEMBERS-1:0]                susp_vec;
   logic                              any_suspect;
   logic                              any_known;
   logic [hbt_pkg::MEMBER_W-1:0]      susp_slot;
   logic [hbt_pkg::WAIT_W-1:0]        wait_ff;
   logic                              accept;
   logic                              sweep_end;

   logic                              pend_ff, pend_in;
   logic [hbt_pkg::MEMBER_W-1:0]      pend_slot_ff, pend_slot_in;
   logic                              found_ff, found_in;

   logic                              strobe_ff, strobe_in;
   logic                              suspect_ff, suspect_in;
   logic [hbt_pkg::MEMBER_W-1:0]      slot_ff, slot_in;
   logic                              unknown_ff, unknown_in;
   logic                              last_ff, last_in;

   assign accept    = start && (state_ff == hbt_pkg::ST_IDLE);
   assign sweep_end = tok_chain[MEMBERS].active;

   always_comb begin
      tok_in        = tok_ff;
      tok_in.active = accept;
      if (accept) begin
         tok_in.op     = hbt_pkg::op_type'(req_opcode);
         tok_in.member = req_member;
      end
   end

   assign tok_chain[0] = tok_ff;

   for (genvar g = 0; g < MEMBERS; g++) begin : g_cell
      hbt_cell #(
         .INDEX(g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .tok_in       (tok_chain[g]),
         .initial_wait (wait_ff),
         .tok_out      (tok_chain[g+1]),
         .stat         (stats[g])
      );
   end

   always_comb begin
      any_known = 1'b0;
      susp_slot = '0;
      for (int i = 0; i < MEMBERS; i++) begin
         susp_vec[i] = stats[i].suspect;
         any_known   = any_known | stats[i].known;
         susp_slot   = susp_slot | stats[i].slot;
      end
      any_suspect = |susp_vec;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hbt_pkg::ST_IDLE: begin
            if (start) begin
               state_in = hbt_pkg::ST_SWEEP;
            end
         end
         hbt_pkg::ST_SWEEP: begin
            if (sweep_end) begin
               state_in = hbt_pkg::ST_IDLE;
            end
         end
         default: state_in = hbt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      strobe_in    = 1'b0;
      suspect_in   = 1'b0;
      slot_in      = '0;
      unknown_in   = 1'b0;
      last_in      = 1'b0;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      found_in     = found_ff | any_known;
      if (accept) begin
         pend_in  = 1'b0;
         found_in = 1'b0;
      end
      if (state_ff == hbt_pkg::ST_SWEEP) begin
         if (any_suspect) begin
            if (pend_ff) begin
               strobe_in  = 1'b1;
               suspect_in = 1'b1;
               slot_in    = pend_slot_ff;
            end
            pend_in      = 1'b1;
            pend_slot_in = susp_slot;
         end
         if (sweep_end) begin
            pend_in = 1'b0;
            if (pend_ff) begin
               strobe_in  = 1'b1;
               suspect_in = 1'b1;
               slot_in    = pend_slot_ff;
               last_in    = 1'b1;
            end else if ((tok_ff.op == hbt_pkg::OP_BEAT) && !found_ff) begin
               strobe_in  = 1'b1;
               slot_in    = tok_ff.member;
               unknown_in = 1'b1;
               last_in    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbt_pkg::ST_IDLE;
         tok_ff       <= '0;
         wait_ff      <= hbt_pkg::INIT_WAIT_RESET;
         pend_ff      <= 1'b0;
         pend_slot_ff <= '0;
         found_ff     <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tok_ff       <= tok_in;
         pend_ff      <= pend_in;
         pend_slot_ff <= pend_slot_in;
         found_ff     <= found_in;
         strobe_ff    <= strobe_in;
         if (csr_we) begin
            wait_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      suspect_ff <= suspect_in;
      slot_ff    <= slot_in;
      unknown_ff <= unknown_in;
      last_ff    <= last_in;
   end

   assign busy           = (state_ff != hbt_pkg::ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_suspect    = suspect_ff;
   assign rsp_member_out = slot_ff;
   assign rsp_unknown    = unknown_ff;
   assign rsp_last       = last_ff;

`ifndef SYNTHESIS
   a_strobe_after_sweep: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == hbt_pkg::ST_SWEEP))
      else $error("Result appeared without a sweep in progress.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("Accepted request did not raise busy.");

   a_one_suspect: assert property (@(posedge clock) disable iff (reset)
      $onehot0(susp_vec))
      else $error("More than one cell flagged a suspect in one cycle.");

   a_unknown_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_unknown) |-> (rsp_last && !rsp_suspect))
      else $error("Unknown beat result was not a lone final result.");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hbt_pkg::ST_IDLE) |-> !pend_ff)
      else $error("Suspect left pending after the sweep ended.");
`endif

endmodule

FILE: bench/hbt_table_checker.sv
`timescale 1ns / 1ps

module hbt_table_checker #(
   parameter int SLOTS = hbt_pkg::MEMBERS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic [hbt_pkg::MEMBER_W-1:0] req_member,
   input  logic                         rsp_strobe,
   input  logic                         rsp_suspect,
   input  logic [hbt_pkg::MEMBER_W-1:0] rsp_member_out,
   input  logic                         rsp_unknown,
   input  logic                         rsp_last,
   input  logic                         csr_we,
   input  logic [hbt_pkg::WAIT_W-1:0]   csr_wdata,
   output int                           mismatches,
   output int                           reports_pending
);

   typedef struct packed {
      logic                         suspect;
      logic [hbt_pkg::MEMBER_W-1:0] member;
      logic                         unknown;
      logic                         last;
   } report_type;

   logic                              present_q [SLOTS];
   logic                              heard_q [SLOTS];
   logic signed [hbt_pkg::CD_W-1:0]   count_q [SLOTS];
   logic [hbt_pkg::WAIT_W-1:0]        limit_q [SLOTS];
   logic [hbt_pkg::WAIT_W-1:0]        init_wait_q;
   report_type                        expected_q [$];
   int                                miss_count = 0;

   assign mismatches = miss_count;

   function automatic report_type make_report(input logic s, input logic [3:0] m,
                                              input logic u, input logic l);
      report_type r;
      r.suspect = s;
      r.member  = m;
      r.unknown = u;
      r.last    = l;
      return r;
   endfunction

   task automatic note_miss(input string what, input report_type want,
                            input report_type got);
      miss_count++;
      if (miss_count <= 10) begin
         $display("%0t: %s: expected suspect=%0d member=%0d unknown=%0d last=%0d,",
                  $realtime, what, want.suspect, want.member, want.unknown, want.last);
         $display("   got suspect=%0d member=%0d unknown=%0d last=%0d",
                  got.suspect, got.member, got.unknown, got.last);
      end
   endtask

   task automatic predict_transfer(input hbt_pkg::op_type op,
                                   input logic [hbt_pkg::MEMBER_W-1:0] m);
      int      grown;
      int      found;
      logic    valid;
      found = 0;
      valid = int'(m) < SLOTS;
      case (op)
         hbt_pkg::OP_BEAT: begin
            if (!valid || !present_q[m]) begin
               expected_q.insert(expected_q.size(), make_report(1'b0, m, 1'b1, 1'b1));
            end else if (!heard_q[m]) begin
               heard_q[m] = 1'b1;
               count_q[m] = $signed({2'b00, limit_q[m]});
            end else begin
               grown = 2 * (int'(limit_q[m]) - int'(count_q[m]));
               if (grown < int'(limit_q[m])) grown = int'(limit_q[m]);
               if (grown > int'(hbt_pkg::WAIT_MAX)) grown = int'(hbt_pkg::WAIT_MAX);
               limit_q[m] = grown[hbt_pkg::WAIT_W-1:0];
               count_q[m] = grown[hbt_pkg::CD_W-1:0];
            end
         end
         hbt_pkg::OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (present_q[i] && heard_q[i]) begin
                  if (count_q[i] != hbt_pkg::CD_MIN) count_q[i] = count_q[i] - 16'sd1;
                  if (2 * int'(count_q[i]) <= -3 * int'(limit_q[i]) && found < 16) begin
                     expected_q.insert(expected_q.size(),
                                       make_report(1'b1, i[3:0], 1'b0, 1'b0));
                     found++;
                  end
               end
            end
            if (found > 0) begin
               expected_q[expected_q.size() - 1].last = 1'b1;
            end
         end
         hbt_pkg::OP_ADD: begin
            if (valid && !present_q[m]) begin
               present_q[m] = 1'b1;
               heard_q[m]   = 1'b0;
               count_q[m]   = '0;
               limit_q[m]   = init_wait_q;
            end
         end
         default: begin
            if (valid) begin
               present_q[m] = 1'b0;
               heard_q[m]   = 1'b0;
               count_q[m]   = '0;
               limit_q[m]   = '0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      report_type want;
      report_type got;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            present_q[i] = 1'b0;
            heard_q[i]   = 1'b0;
            count_q[i]   = '0;
            limit_q[i]   = '0;
         end
         init_wait_q = hbt_pkg::INIT_WAIT_RESET;
         expected_q.delete();
      end else begin
         if (rsp_strobe) begin
            got = make_report(rsp_suspect, rsp_member_out, rsp_unknown, rsp_last);
            if (expected_q.size() == 0) begin
               note_miss("unexpected transfer", '0, got);
            end else begin
               want = expected_q.pop_front();
               if (got.suspect !== want.suspect || got.member !== want.member ||
                   got.unknown !== want.unknown || got.last !== want.last) begin
                  note_miss("mismatch", want, got);
               end
            end
         end
         if (csr_we) init_wait_q = csr_wdata;
         if (start && !busy) predict_transfer(hbt_pkg::op_type'(req_opcode), req_member);
      end
      reports_pending <= expected_q.size();
   end

endmodule

FILE: bench/tb_heartbeat_adaptive_timeout_table_core.sv
`timescale 1ns / 1ps

module tb_heartbeat_adaptive_timeout_table_core;

   localparam int SLOTS  = hbt_pkg::MEMBERS_DEF;
   localparam int SETTLE = SLOTS + 4;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_opcode = '0;
   logic [hbt_pkg::MEMBER_W-1:0] req_member = '0;
   logic                         rsp_strobe;
   logic                         rsp_suspect;
   logic [hbt_pkg::MEMBER_W-1:0] rsp_member_out;
   logic                         rsp_unknown;
   logic                         rsp_last;
   logic                         csr_we = 1'b0;
   logic [hbt_pkg::WAIT_W-1:0]   csr_wdata = '0;
   int                           miss_total;
   int                           open_reports;

   always #5 clock = ~clock;

   heartbeat_adaptive_timeout_table_core #(
      .MEMBERS(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_member(req_member),
      .rsp_strobe(rsp_strobe),
      .rsp_suspect(rsp_suspect),
      .rsp_member_out(rsp_member_out),
      .rsp_unknown(rsp_unknown),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   hbt_table_checker #(
      .SLOTS(SLOTS)
   ) table_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_member(req_member),
      .rsp_strobe(rsp_strobe),
      .rsp_suspect(rsp_suspect),
      .rsp_member_out(rsp_member_out),
      .rsp_unknown(rsp_unknown),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .mismatches(miss_total),
      .reports_pending(open_reports)
   );

   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic send(input hbt_pkg::op_type op, input logic [hbt_pkg::MEMBER_W-1:0] m);
      start      <= 1'b1;
      req_opcode <= op;
      req_member <= m;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (busy || open_reports != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_wait(input logic [hbt_pkg::WAIT_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [hbt_pkg::MEMBER_W-1:0] pick_slot();
      return hbt_pkg::MEMBER_W'($urandom_range(0, SLOTS - 1));
   endfunction

   function automatic hbt_pkg::op_type pick_op();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 35) return hbt_pkg::OP_BEAT;
      if (roll < 70) return hbt_pkg::OP_TICK;
      if (roll < 85) return hbt_pkg::OP_ADD;
      return hbt_pkg::OP_REMOVE;
   endfunction

   task automatic random_phase(input logic [hbt_pkg::WAIT_W-1:0] wait_value, input int count);
      int burst;
      burst = 0;
      write_wait(wait_value);
      for (int k = 0; k < 4; k++) send(hbt_pkg::OP_ADD, pick_slot());
      for (int k = 0; k < count; k++) begin
         if (burst == 0) begin
            burst = int'($urandom_range(1, 8));
            if ($urandom_range(0, 2) != 0) pause(int'($urandom_range(1, 25)));
         end
         send(pick_op(), pick_slot());
         burst--;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send(hbt_pkg::OP_BEAT, 4'd3);
      send(hbt_pkg::OP_ADD, 4'd0);
      send(hbt_pkg::OP_ADD, 4'd15);
      send(hbt_pkg::OP_ADD, 4'd0);
      send(hbt_pkg::OP_BEAT, 4'd0);
      send(hbt_pkg::OP_BEAT, 4'd0);
      send(hbt_pkg::OP_TICK, 4'd9);
      send(hbt_pkg::OP_REMOVE, 4'd3);
      send(hbt_pkg::OP_REMOVE, 4'd15);
      send(hbt_pkg::OP_BEAT, 4'd15);
      send(hbt_pkg::OP_TICK, 4'd0);

      write_wait('0);
      send(hbt_pkg::OP_ADD, 4'd1);
      send(hbt_pkg::OP_BEAT, 4'd1);
      send(hbt_pkg::OP_TICK, 4'd15);
      send(hbt_pkg::OP_ADD, 4'd5);
      send(hbt_pkg::OP_BEAT, 4'd5);
      send(hbt_pkg::OP_TICK, 4'd0);
      send(hbt_pkg::OP_BEAT, 4'd1);
      send(hbt_pkg::OP_REMOVE, 4'd5);

      write_wait(hbt_pkg::WAIT_MAX);
      send(hbt_pkg::OP_ADD, 4'd2);
      send(hbt_pkg::OP_BEAT, 4'd2);
      send(hbt_pkg::OP_BEAT, 4'd2);
      send(hbt_pkg::OP_TICK, 4'd0);

      write_wait('0);
      send(hbt_pkg::OP_ADD, 4'd7);
      send(hbt_pkg::OP_BEAT, 4'd7);
      write_wait(hbt_pkg::WAIT_MAX);
      send(hbt_pkg::OP_ADD, 4'd9);
      send(hbt_pkg::OP_BEAT, 4'd9);
      send(hbt_pkg::OP_BEAT, 4'd9);
      send(hbt_pkg::OP_BEAT, 4'd7);
      send(hbt_pkg::OP_TICK, 4'd0);
      for (int k = 0; k < SLOTS; k++) send(hbt_pkg::OP_REMOVE, k[3:0]);

      random_phase(14'd1, 17);
      random_phase(hbt_pkg::WAIT_W'($urandom_range(2, 12)), 17);
      random_phase(hbt_pkg::WAIT_MAX, 17);
      random_phase(hbt_pkg::WAIT_W'($urandom_range(1, 6)), 17);

      settle();
      if (miss_total == 0 && open_reports == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
